@@ hdl/ptb_pkg.sv @@
// Package for the periodic timer bank: command codes, controller states,
// and the command/status structs between controller and datapath. No dependencies.
package ptb_pkg;

   localparam int MASK_W = 8;

   typedef enum logic [2:0] {
      CMD_TICK  = 3'd0,
      CMD_SET   = 3'd1,
      CMD_KILL  = 3'd2,
      CMD_TAKE  = 3'd3,
      CMD_QUERY = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_EXEC,
      ST_TAKE_INIT,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic req_ready;
      logic latch_req;
      logic tick_step;
      logic set_step;
      logic kill_step;
      logic take_init;
      logic scan_step;
      logic sel_walk;
      logic sel_scan;
      logic load_rsp;
   } ctrl_type;

   typedef struct packed {
      logic       req_valid;
      logic [2:0] req_cmd;
      logic [2:0] held_cmd;
      logic       walk_last;
      logic       scan_hit;
      logic       scan_last;
      logic       rsp_free;
   } status_type;

endpackage

@@ hdl/ptb_if.sv @@
// Request and response channel interfaces of the periodic timer bank.
// Valid/ready handshake; no dependencies.
interface ptb_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [2:0]  timer_index;
   logic [31:0] interval;
   logic        use_callback;

   modport source (output valid, output cmd, output timer_index, output interval,
                   output use_callback, input ready);
   modport sink   (input valid, input cmd, input timer_index, input interval,
                   input use_callback, output ready);
endinterface

interface ptb_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  ready_index;
   logic        timed_out;
   logic [31:0] elapsed_ticks;
   logic [7:0]  callback_mask;

   modport source (output valid, output ready_index, output timed_out,
                   output elapsed_ticks, output callback_mask, input ready);
   modport sink   (input valid, input ready_index, input timed_out,
                   input elapsed_ticks, input callback_mask, output ready);
endinterface

@@ hdl/ptb_ctrl.sv @@
// Controller of the periodic timer bank: sequences tick walks, set/kill,
// take-ready scans and result loading. Depends on ptb_pkg.
module ptb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  ptb_pkg::status_type  stat,
   output ptb_pkg::ctrl_type    ctrl
);

   ptb_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      case (state_ff)
         ptb_pkg::ST_IDLE: begin
            ctrl.req_ready = 1'b1;
            if (stat.req_valid) begin
               ctrl.latch_req = 1'b1;
               case (stat.req_cmd)
                  ptb_pkg::CMD_TICK: state_in = ptb_pkg::ST_TICK;
                  ptb_pkg::CMD_SET:  state_in = ptb_pkg::ST_EXEC;
                  ptb_pkg::CMD_KILL: state_in = ptb_pkg::ST_EXEC;
                  ptb_pkg::CMD_TAKE: state_in = ptb_pkg::ST_TAKE_INIT;
                  default:           state_in = ptb_pkg::ST_DONE;
               endcase
            end
         end
         ptb_pkg::ST_TICK: begin
            ctrl.sel_walk  = 1'b1;
            ctrl.tick_step = 1'b1;
            if (stat.walk_last) begin
               state_in = ptb_pkg::ST_DONE;
            end
         end
         ptb_pkg::ST_EXEC: begin
            if (stat.held_cmd == ptb_pkg::CMD_SET) begin
               ctrl.set_step = 1'b1;
            end else begin
               ctrl.kill_step = 1'b1;
            end
            state_in = ptb_pkg::ST_DONE;
         end
         ptb_pkg::ST_TAKE_INIT: begin
            ctrl.take_init = 1'b1;
            state_in       = ptb_pkg::ST_SCAN;
         end
         ptb_pkg::ST_SCAN: begin
            ctrl.sel_scan  = 1'b1;
            ctrl.scan_step = 1'b1;
            if (stat.scan_hit || stat.scan_last) begin
               state_in = ptb_pkg::ST_DONE;
            end
         end
         ptb_pkg::ST_DONE: begin
            // wait for the output register to free up
            if (stat.rsp_free) begin
               ctrl.load_rsp = 1'b1;
               state_in      = ptb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ptb_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ hdl/ptb_datapath.sv @@
// Datapath of the periodic timer bank: timer state, walk counter, scan pointer,
// request latch and response register. Depends on ptb_pkg and ptb_if.
module ptb_datapath #(
   parameter int NUM_TIMERS  = 8,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   ptb_req_if.sink              req_chan,
   ptb_rsp_if.source            rsp_chan,
   input  ptb_pkg::ctrl_type    ctrl,
   output ptb_pkg::status_type  stat
);

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int PTR_W = $clog2(NUM_TIMERS + 1);

   // timer state
   logic                   en_ff   [NUM_TIMERS];
   logic                   cb_ff   [NUM_TIMERS];
   logic                   flag_ff [NUM_TIMERS];
   logic [COUNT_WIDTH-1:0] cnt_ff  [NUM_TIMERS];
   logic [COUNT_WIDTH-1:0] rld_ff  [NUM_TIMERS];
   logic [PTR_W-1:0]       ptr_ff;
   logic [IDX_W-1:0]       walk_ff;
   logic [ptb_pkg::MASK_W-1:0] mask_ff;

   // latched request
   logic [2:0]             cmd_ff;
   logic [IDX_W-1:0]       idx_ff;
   logic                   idx_ok_ff;
   logic [COUNT_WIDTH-1:0] ivl_ff;
   logic                   ucb_ff;

   // response register
   logic        rsp_valid_ff;
   logic [3:0]  rsp_ready_idx_ff;
   logic        rsp_tmo_ff;
   logic [31:0] rsp_elapsed_ff;
   logic [7:0]  rsp_mask_ff;

   logic [IDX_W-1:0]       rd_addr;
   logic                   ent_en;
   logic                   ent_cb;
   logic                   ent_flag;
   logic [COUNT_WIDTH-1:0] ent_cnt;
   logic [COUNT_WIDTH-1:0] ent_rld;
   logic [COUNT_WIDTH-1:0] ent_diff;
   logic [COUNT_WIDTH-1:0] cnt_dec;
   logic                   req_idx_ok;
   logic                   rsp_free;

   // one shared address for all entry accesses
   always_comb begin
      if (ctrl.sel_walk) begin
         rd_addr = walk_ff;
      end else if (ctrl.sel_scan) begin
         rd_addr = ptr_ff[IDX_W-1:0];
      end else begin
         rd_addr = idx_ff;
      end
   end

   assign ent_en     = en_ff[rd_addr];
   assign ent_cb     = cb_ff[rd_addr];
   assign ent_flag   = flag_ff[rd_addr];
   assign ent_cnt    = cnt_ff[rd_addr];
   assign ent_rld    = rld_ff[rd_addr];
   // elapsed ticks wrap at the count width
   assign ent_diff   = ent_rld - ent_cnt;
   assign cnt_dec    = ent_cnt - COUNT_WIDTH'(1);
   assign req_idx_ok = (32'(req_chan.timer_index) < 32'(NUM_TIMERS));
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (ctrl.latch_req) begin
         cmd_ff    <= req_chan.cmd;
         idx_ff    <= req_idx_ok ? IDX_W'(req_chan.timer_index) : '0;
         idx_ok_ff <= req_idx_ok;
         ivl_ff    <= COUNT_WIDTH'(req_chan.interval);
         ucb_ff    <= req_chan.use_callback;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TIMERS; i++) begin
            en_ff[i]   <= 1'b0;
            cb_ff[i]   <= 1'b0;
            flag_ff[i] <= 1'b0;
            cnt_ff[i]  <= '0;
            rld_ff[i]  <= '0;
         end
      end else begin
         if (ctrl.tick_step && ent_en && ent_cnt != '0) begin
            if (cnt_dec == '0) begin
               cnt_ff[rd_addr] <= ent_rld;
               if (!ent_cb) begin
                  flag_ff[rd_addr] <= 1'b1;
               end
            end else begin
               cnt_ff[rd_addr] <= cnt_dec;
            end
         end
         if (ctrl.set_step && idx_ok_ff) begin
            en_ff[rd_addr]   <= 1'b1;
            cnt_ff[rd_addr]  <= ivl_ff;
            rld_ff[rd_addr]  <= ivl_ff;
            cb_ff[rd_addr]   <= ucb_ff;
            flag_ff[rd_addr] <= 1'b0;
         end
         if (ctrl.kill_step && idx_ok_ff) begin
            en_ff[rd_addr] <= 1'b0;
         end
         if (ctrl.scan_step && ent_en && ent_flag) begin
            flag_ff[rd_addr] <= 1'b0;
         end
      end
   end

   // walk counter and callback mask for ticks
   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff <= '0;
         mask_ff <= '0;
      end else if (ctrl.latch_req) begin
         walk_ff <= '0;
         mask_ff <= '0;
      end else if (ctrl.tick_step) begin
         walk_ff <= walk_ff + IDX_W'(1);
         if (ent_en && ent_cnt != '0 && cnt_dec == '0 && ent_cb
             && 32'(walk_ff) < 32'(ptb_pkg::MASK_W)) begin
            mask_ff[3'(walk_ff)] <= 1'b1;
         end
      end
   end

   // scan pointer stays on a found timer and steps past a miss; past the end it wraps to zero at the next take
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else if (ctrl.take_init) begin
         if (ptr_ff >= PTR_W'(NUM_TIMERS)) begin
            ptr_ff <= '0;
         end
      end else if (ctrl.scan_step && !(ent_en && ent_flag)) begin
         ptr_ff <= ptr_ff + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_rsp) begin
         rsp_ready_idx_ff <= (cmd_ff == ptb_pkg::CMD_TAKE) ? 4'(ptr_ff) : 4'(NUM_TIMERS);
         rsp_tmo_ff       <= idx_ok_ff && ent_en && ent_flag;
         rsp_elapsed_ff   <= (idx_ok_ff && ent_en) ? 32'(ent_diff) : 32'd0;
         rsp_mask_ff      <= (cmd_ff == ptb_pkg::CMD_TICK) ? mask_ff : '0;
      end
   end

   assign req_chan.ready         = ctrl.req_ready;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.ready_index   = rsp_ready_idx_ff;
   assign rsp_chan.timed_out     = rsp_tmo_ff;
   assign rsp_chan.elapsed_ticks = rsp_elapsed_ff;
   assign rsp_chan.callback_mask = rsp_mask_ff;

   always_comb begin
      stat           = '0;
      stat.req_valid = req_chan.valid;
      stat.req_cmd   = req_chan.cmd;
      stat.held_cmd  = cmd_ff;
      stat.walk_last = (walk_ff == IDX_W'(NUM_TIMERS - 1));
      stat.scan_hit  = ent_en && ent_flag;
      stat.scan_last = (ptr_ff == PTR_W'(NUM_TIMERS - 1));
      stat.rsp_free  = rsp_free;
   end

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= PTR_W'(NUM_TIMERS))
      else $error("scan pointer beyond timer count");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.load_rsp |-> rsp_free)
      else $error("response loaded over a pending transfer");

   a_mask_tick_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ready_idx_ff != 4'(NUM_TIMERS)) |-> rsp_mask_ff == '0)
      else $error("callback mask set on a take-ready result");

   a_hit_clears: assert property (@(posedge clock) disable iff (reset)
      (ctrl.scan_step && ent_en && ent_flag) |=> ctrl.load_rsp || !ctrl.scan_step)
      else $error("scan kept going after a hit");

endmodule

@@ hdl/periodic_timer_bank_top.sv @@
// Top level of the periodic timer bank: controller plus datapath.
// Depends on ptb_pkg, ptb_if, ptb_ctrl and ptb_datapath.
//
//   channel    dir  handshake     payload
//   req_chan   in   valid/ready   cmd, timer_index, interval, use_callback
//   rsp_chan   out  valid/ready   ready_index, timed_out, elapsed_ticks, callback_mask
//
// One item at a time; a tick walks the timers one per cycle, set and kill
// pass through the execute state, a query goes straight to its result, and take-ready
// scans from its pointer, one timer checked per cycle, up to a hit or the last timer.
// Reset is synchronous and clears every timer; no clearing pass is needed.
// A registered response lets the next request be accepted while a result waits;
// the controller holds its next result until that register is free.
module periodic_timer_bank_top #(
   parameter int NUM_TIMERS  = 8,
   parameter int COUNT_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   ptb_req_if.sink    req_chan,
   ptb_rsp_if.source  rsp_chan
);

   ptb_pkg::ctrl_type   ctrl;
   ptb_pkg::status_type stat;

   ptb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   ptb_datapath #(
      .NUM_TIMERS  (NUM_TIMERS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .ctrl     (ctrl),
      .stat     (stat)
   );

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for periodic_timer_bank_top: directed table, then random traffic.
// Depends on ptb_pkg, ptb_if and the timer bank RTL.
`timescale 1ns / 100ps

module testbench;

   localparam int           NUM_TIMERS = 8;
   localparam logic [3:0]   NO_TIMER   = 4'd8;
   localparam logic [2:0]   CMD_RSVD5  = 3'd5;
   localparam logic [2:0]   CMD_RSVD6  = 3'd6;
   localparam logic [2:0]   CMD_RSVD7  = 3'd7;
   localparam int           STALL_LIMIT = 5000;
   localparam int           PHASE_ITEMS = 225;
   localparam int           DIR_ITEMS   = 25;
   localparam int           HOLD_AT     = DIR_ITEMS + 2 * PHASE_ITEMS + 30;
   localparam int           HOLD_CYCLES = 300;
   localparam int           DRAIN_CYCLES = 20;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [2:0]  timer_index;
      logic [31:0] interval;
      logic        use_callback;
   } timer_cmd_type;

   typedef struct packed {
      logic [3:0]  ready_index;
      logic        timed_out;
      logic [31:0] elapsed_ticks;
      logic [7:0]  callback_mask;
   } timer_status_type;

   typedef struct packed {
      timer_cmd_type    item;
      logic             typed;
      timer_status_type want;
   } dir_row_type;

   localparam timer_status_type IDLE_STATUS = '{NO_TIMER, 1'b0, 32'd0, 8'h00};

   // Directed table; typed rows carry their expected status, the rest use the predictor.
   localparam dir_row_type DIR_TABLE [0:DIR_ITEMS-1] = '{
      '{'{ptb_pkg::CMD_QUERY, 3'd0, 32'd0,          1'b0}, 1'b1, IDLE_STATUS},  // after reset
      '{'{ptb_pkg::CMD_TICK,  3'd0, 32'd0,          1'b0}, 1'b1, IDLE_STATUS},
      '{'{ptb_pkg::CMD_TAKE,  3'd0, 32'd0,          1'b0}, 1'b1, IDLE_STATUS},  // nothing ready
      '{'{CMD_RSVD5,          3'd7, 32'd0,          1'b0}, 1'b1, IDLE_STATUS},
      '{'{CMD_RSVD7,          3'd0, 32'hFFFF_FFFF,  1'b1}, 1'b1, IDLE_STATUS},
      '{'{ptb_pkg::CMD_SET,   3'd0, 32'd0,          1'b0}, 1'b1, IDLE_STATUS},  // zero interval
      '{'{ptb_pkg::CMD_TICK,  3'd0, 32'd0,          1'b0}, 1'b0, IDLE_STATUS},
      '{'{ptb_pkg::CMD_SET,   3'd7, 32'hFFFF_FFFF,  1'b1}, 1'b1, IDLE_STATUS},
      '{'{ptb_pkg::CMD_TICK,  3'd7, 32'hFFFF_FFFF,  1'b1}, 1'b0, IDLE_STATUS},
      '{'{ptb_pkg::CMD_QUERY, 3'd7, 32'd0,          1'b0}, 1'b1,
        '{NO_TIMER, 1'b0, 32'd1, 8'h00}},
      '{'{ptb_pkg::CMD_SET,   3'd1, 32'd1,          1'b1}, 1'b1, IDLE_STATUS},
      '{'{ptb_pkg::CMD_TICK,  3'd0, 32'd0,          1'b0}, 1'b0, IDLE_STATUS},  // callback fires
      '{'{ptb_pkg::CMD_SET,   3'd2, 32'd1,          1'b0}, 1'b0, IDLE_STATUS},
      '{'{ptb_pkg::CMD_TICK,  3'd2, 32'd0,          1'b0}, 1'b0, IDLE_STATUS},  // flag latches
      '{'{ptb_pkg::CMD_QUERY, 3'd2, 32'd0,          1'b0}, 1'b1,
        '{NO_TIMER, 1'b1, 32'd0, 8'h00}},
      '{'{ptb_pkg::CMD_TAKE,  3'd2, 32'd0,          1'b0}, 1'b0, IDLE_STATUS},
      '{'{ptb_pkg::CMD_TAKE,  3'd0, 32'd0,          1'b0}, 1'b0, IDLE_STATUS},  // misses; pointer runs past the end
      '{'{ptb_pkg::CMD_TICK,  3'd5, 32'd0,          1'b1}, 1'b0, IDLE_STATUS},
      '{'{ptb_pkg::CMD_KILL,  3'd2, 32'd0,          1'b0}, 1'b0, IDLE_STATUS},  // flag kept
      '{'{ptb_pkg::CMD_TAKE,  3'd0, 32'd0,          1'b0}, 1'b0, IDLE_STATUS},
      '{'{ptb_pkg::CMD_SET,   3'd2, 32'd1,          1'b0}, 1'b0, IDLE_STATUS},
      '{'{ptb_pkg::CMD_KILL,  3'd7, 32'hFFFF_FFFF,  1'b1}, 1'b1, IDLE_STATUS},
      '{'{CMD_RSVD6,          3'd4, 32'hAAAA_5555,  1'b0}, 1'b0, IDLE_STATUS},
      '{'{ptb_pkg::CMD_SET,   3'd5, 32'h8000_0000,  1'b1}, 1'b0, IDLE_STATUS},
      '{'{ptb_pkg::CMD_QUERY, 3'd5, 32'hFFFF_FFFF,  1'b1}, 1'b0, IDLE_STATUS}
   };

   logic clock;
   logic reset;

   ptb_req_if req_bus ();
   ptb_rsp_if rsp_bus ();

   periodic_timer_bank_top #(
      .NUM_TIMERS (NUM_TIMERS),
      .COUNT_WIDTH(32)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   // Shadow copy of the timer bank
   logic        tmr_en     [NUM_TIMERS];
   logic [31:0] tmr_count  [NUM_TIMERS];
   logic [31:0] tmr_reload [NUM_TIMERS];
   logic        tmr_cb     [NUM_TIMERS];
   logic        tmr_flag   [NUM_TIMERS];
   logic [3:0]  scan_ptr;

   timer_status_type status_due [$];
   logic             offer_typed;
   timer_status_type offer_want;

   int send_idle_pct;
   int recv_idle_pct;
   int n_errors;
   int n_cmds_taken;
   int n_status_seen;
   int n_ticks;
   int n_fired;
   int n_found;
   int idle_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      for (int t = 0; t < NUM_TIMERS; t++) begin
         tmr_en[t]     = 1'b0;
         tmr_count[t]  = '0;
         tmr_reload[t] = '0;
         tmr_cb[t]     = 1'b0;
         tmr_flag[t]   = 1'b0;
      end
      scan_ptr = '0;
   end

   function automatic timer_status_type predict_timer_status(timer_cmd_type it);
      timer_status_type st;
      logic             found;
      st = IDLE_STATUS;
      found = 1'b0;
      case (it.cmd)
         ptb_pkg::CMD_TICK: begin
            n_ticks++;
            for (int t = 0; t < NUM_TIMERS; t++) begin
               if (tmr_en[t] && tmr_count[t] != 0) begin
                  tmr_count[t] = tmr_count[t] - 1;
                  if (tmr_count[t] == 0) begin
                     if (tmr_cb[t]) begin
                        st.callback_mask[t] = 1'b1;
                        n_fired++;
                     end else begin
                        tmr_flag[t] = 1'b1;
                     end
                     tmr_count[t] = tmr_reload[t];
                  end
               end
            end
         end
         ptb_pkg::CMD_SET: begin
            tmr_en[it.timer_index]     = 1'b1;
            tmr_count[it.timer_index]  = it.interval;
            tmr_reload[it.timer_index] = it.interval;
            tmr_cb[it.timer_index]     = it.use_callback;
            tmr_flag[it.timer_index]   = 1'b0;
         end
         ptb_pkg::CMD_KILL: tmr_en[it.timer_index] = 1'b0;
         ptb_pkg::CMD_TAKE: begin
            if (scan_ptr >= NUM_TIMERS) scan_ptr = '0;
            // pointer stays on a found timer, so the next scan restarts there
            while (!found && scan_ptr < NUM_TIMERS) begin
               if (tmr_en[scan_ptr] && tmr_flag[scan_ptr]) begin
                  tmr_flag[scan_ptr] = 1'b0;
                  found = 1'b1;
                  n_found++;
               end else begin
                  scan_ptr++;
               end
            end
            st.ready_index = scan_ptr;
         end
         default: ;
      endcase
      if (tmr_en[it.timer_index]) begin
         st.timed_out     = tmr_flag[it.timer_index];
         st.elapsed_ticks = tmr_reload[it.timer_index] - tmr_count[it.timer_index];
      end
      return st;
   endfunction

   function automatic timer_cmd_type random_timer_cmd();
      timer_cmd_type it;
      int            pick;
      it.timer_index  = 3'($urandom_range(NUM_TIMERS - 1));
      it.interval     = $urandom;
      it.use_callback = 1'($urandom_range(1));
      pick = $urandom_range(99);
      if (pick < 40) begin
         it.cmd = ptb_pkg::CMD_TICK;
      end else if (pick < 56) begin
         it.cmd = ptb_pkg::CMD_SET;
         pick = $urandom_range(99);
         // mostly short periods so timers expire often
         if (pick < 70) it.interval = 32'($urandom_range(6, 1));
         else if (pick < 80) it.interval = '0;
      end else if (pick < 71) begin
         it.cmd = ptb_pkg::CMD_TAKE;
      end else if (pick < 85) begin
         it.cmd = ptb_pkg::CMD_QUERY;
      end else if (pick < 92) begin
         it.cmd = ptb_pkg::CMD_KILL;
      end else begin
         it.cmd = 3'($urandom_range(7, 5));
      end
      return it;
   endfunction

   task automatic compare_status(timer_status_type want, timer_status_type got);
      if (got.ready_index !== want.ready_index) begin
         $error("ready_index: expected %0d, actual %0d", want.ready_index, got.ready_index);
         n_errors++;
      end
      if (got.timed_out !== want.timed_out) begin
         $error("timed_out: expected %0d, actual %0d", want.timed_out, got.timed_out);
         n_errors++;
      end
      if (got.elapsed_ticks !== want.elapsed_ticks) begin
         $error("elapsed_ticks: expected %0h, actual %0h",
                want.elapsed_ticks, got.elapsed_ticks);
         n_errors++;
      end
      if (got.callback_mask !== want.callback_mask) begin
         $error("callback_mask: expected %0h, actual %0h",
                want.callback_mask, got.callback_mask);
         n_errors++;
      end
   endtask

   task automatic send_timer_cmd(timer_cmd_type it, logic typed, timer_status_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.cmd          <= it.cmd;
      req_bus.timer_index  <= it.timer_index;
      req_bus.interval     <= it.interval;
      req_bus.use_callback <= it.use_callback;
      offer_typed          <= typed;
      offer_want           <= want;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Monitor: predicts on every request transfer, checks every response transfer
   always @(posedge clock) begin : monitor
      timer_cmd_type    it;
      timer_status_type st;
      timer_status_type got;
      if (!reset) begin
         idle_cycles++;
         if (req_bus.valid && req_bus.ready) begin
            it = '{req_bus.cmd, req_bus.timer_index, req_bus.interval, req_bus.use_callback};
            st = predict_timer_status(it);
            if (offer_typed) st = offer_want;
            status_due.push_back(st);
            n_cmds_taken++;
            idle_cycles = 0;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.ready_index, rsp_bus.timed_out, rsp_bus.elapsed_ticks,
                    rsp_bus.callback_mask};
            if (status_due.size() == 0) begin
               $error("response transfer with no status pending");
               n_errors++;
            end else begin
               compare_status(status_due.pop_front(), got);
            end
            n_status_seen++;
            idle_cycles = 0;
         end
      end
   end

   // Receiver: random stalls plus one long hold-off to back up the block
   initial begin : receiver
      int   hold_left;
      logic hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && n_cmds_taken >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin : watchdog
      idle_cycles = 0;
      @(negedge reset);
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      n_errors      = 0;
      n_cmds_taken  = 0;
      n_status_seen = 0;
      n_ticks       = 0;
      n_fired       = 0;
      n_found       = 0;
      send_idle_pct = 29;
      recv_idle_pct = 55;
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.cmd          <= ptb_pkg::CMD_QUERY;
      req_bus.timer_index  <= '0;
      req_bus.interval     <= '0;
      req_bus.use_callback <= 1'b0;
      offer_typed          <= 1'b0;
      offer_want           <= IDLE_STATUS;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_ITEMS; i++)
         send_timer_cmd(DIR_TABLE[i].item, DIR_TABLE[i].typed, DIR_TABLE[i].want);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 29;
               recv_idle_pct = 55;
            end
            1: begin
               send_idle_pct = 55;
               recv_idle_pct = 29;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++)
            send_timer_cmd(random_timer_cmd(), 1'b0, IDLE_STATUS);
      end
      req_bus.valid <= 1'b0;

      while (status_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d commands and %0d status transfers: %0d ticks, %0d callbacks,",
               n_cmds_taken, n_status_seen, n_ticks, n_fired);
      $display("%0d expired timers taken, %0d mismatches.", n_found, n_errors);
      if (n_errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
